>>> hdl/ssstat_pkg.sv
// shared types and constants for the streaming sample statistics block
`default_nettype none

package ssstat_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned AVG_W       = 24;
  localparam int unsigned DROP_W      = 16;
  localparam int unsigned SPIKE_W     = 10;
  localparam int unsigned FRAC_BITS   = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH      = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0]        SPIKE_THRESHOLD_RESET = 16'd100;
  localparam logic signed [CFG_W-1:0] RANGE_LOW_RESET       = 16'sd90;
  localparam logic signed [CFG_W-1:0] RANGE_HIGH_RESET      = 16'sd110;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } sample_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]      sample_count;
    logic signed [AVG_W-1:0] average_q8;
    logic [DROP_W-1:0]       largest_drop;
    logic [SPIKE_W-1:0]      spike_count;
    logic [COUNT_W-1:0]      in_range_count;
    logic                    overflow;
  } result_item_t;

  // controller commands to the datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic finish;
  } ssstat_cmd_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIVIDE,
    ST_HOLD
  } ssstat_state_t;

endpackage

`default_nettype wire

>>> hdl/ssstat_ctrl.sv
// controller state machine: sample intake, divide sequencing, result hand-off
`default_nettype none

module ssstat_ctrl #(
  parameter int unsigned DIV_STEPS = 35
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       sample_valid,
  input  wire                       last_sample,
  output logic                      sample_stall,
  output logic                      result_valid,
  input  wire                       result_stall,
  output ssstat_pkg::ssstat_cmd_t   cmd
);
  import ssstat_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  ssstat_state_t     state, state_next;
  logic [STEP_W-1:0] step_count, step_count_next;
  logic              result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      step_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      step_count   <= step_count_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    step_count_next = step_count;
    sample_stall    = 1'b1;
    cmd             = '0;
    unique case (state)
      ST_RUN: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.accept = 1'b1;
          if (last_sample) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.div_start   = 1'b1;
        step_count_next = '0;
        state_next      = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step    = 1'b1;
        step_count_next = step_count + 1'b1;
        if (step_count == LAST_STEP) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // result slot free or emptied this cycle
        if (!result_valid || !result_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase

    if (cmd.finish) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result_valid)
    else $error("result not shown after finish");

  a_divide_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE && step_count == LAST_STEP) |=> state == ST_HOLD)
    else $error("divide did not end after its last step");

  a_load_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> $past(cmd.accept && last_sample))
    else $error("divide started without a closing sample");

endmodule

`default_nettype wire

>>> hdl/ssstat_dp.sv
// datapath: configuration, running statistics, serial divider, result register
`default_nettype none

module ssstat_dp #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  ssstat_pkg::ssstat_cmd_t                cmd,
  input  ssstat_pkg::sample_item_t               sample_data,
  input  wire                                    cfg_write,
  input  wire [ssstat_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [ssstat_pkg::CFG_W-1:0]            cfg_data,
  output ssstat_pkg::result_item_t               result_data
);
  import ssstat_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  localparam int unsigned DIV_W = SUM_W + FRAC_BITS;
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SAMPLES);

  // configuration
  logic [CFG_W-1:0]        spike_threshold;
  logic signed [CFG_W-1:0] range_low;
  logic signed [CFG_W-1:0] range_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      spike_threshold <= SPIKE_THRESHOLD_RESET;
      range_low       <= RANGE_LOW_RESET;
      range_high      <= RANGE_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPIKE_THRESHOLD: spike_threshold <= cfg_data;
        REG_RANGE_LOW:       range_low       <= cfg_data;
        REG_RANGE_HIGH:      range_high      <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [SAMPLE_BITS:0] abs_diff(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b
  );
    logic signed [SAMPLE_BITS:0] d;
    d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
    return d[SAMPLE_BITS] ? (~d + 1'b1) : d;
  endfunction

  // running statistics
  logic signed [SAMPLE_BITS-1:0] prev_sample, prev2_sample;
  logic signed [SUM_W-1:0]       running_sum;
  logic [CNT_W-1:0]              samples_seen;
  logic [DROP_W-1:0]             drop_maximum;
  logic [CNT_W-1:0]              spikes_found;
  logic [CNT_W-1:0]              in_range_found;
  logic                          overflowed;

  logic signed [SAMPLE_BITS-1:0] s;
  logic signed [SAMPLE_BITS:0]   drop_diff;
  logic                          drop_hit;
  logic                          spike_hit;
  logic                          range_hit;
  logic                          full;

  assign s         = sample_data.sample;
  assign full      = (samples_seen >= MAX_COUNT);
  assign drop_diff = {prev_sample[SAMPLE_BITS-1], prev_sample} - {s[SAMPLE_BITS-1], s};
  // a positive drop between 16-bit samples always fits the drop field
  assign drop_hit  = (samples_seen != '0) && !drop_diff[SAMPLE_BITS] && (drop_diff != '0)
                     && (drop_diff[DROP_W-1:0] > drop_maximum);
  assign spike_hit = (samples_seen >= CNT_W'(2))
                     && (abs_diff(prev_sample, prev2_sample) > (SAMPLE_BITS+1)'(spike_threshold))
                     && (abs_diff(prev_sample, s) > (SAMPLE_BITS+1)'(spike_threshold));
  assign range_hit = (s >= range_low) && (s <= range_high);

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      prev_sample    <= '0;
      prev2_sample   <= '0;
      running_sum    <= '0;
      samples_seen   <= '0;
      drop_maximum   <= '0;
      spikes_found   <= '0;
      in_range_found <= '0;
      overflowed     <= 1'b0;
    end else if (cmd.accept) begin
      if (full) begin
        overflowed <= 1'b1;
      end else begin
        if (drop_hit) begin
          drop_maximum <= drop_diff[DROP_W-1:0];
        end
        if (spike_hit) begin
          spikes_found <= spikes_found + 1'b1;
        end
        if (range_hit) begin
          in_range_found <= in_range_found + 1'b1;
        end
        running_sum  <= running_sum + {{(SUM_W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
        samples_seen <= samples_seen + 1'b1;
        prev2_sample <= prev_sample;
        prev_sample  <= s;
      end
    end
  end

  // restoring divider on magnitudes, one quotient bit per step
  logic [SUM_W-1:0] sum_mag;
  logic [DIV_W-1:0] div_quo;
  logic [CNT_W-1:0] div_rem;
  logic             div_neg;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   trial_sub;
  logic             trial_ge;
  logic [DIV_W-1:0] quo_signed;

  assign sum_mag   = running_sum[SUM_W-1] ? (~running_sum + 1'b1) : running_sum;
  assign trial     = {div_rem, div_quo[DIV_W-1]};
  assign trial_sub = trial - {1'b0, samples_seen};
  assign trial_ge  = (trial >= {1'b0, samples_seen});
  assign quo_signed = div_neg ? (~div_quo + 1'b1) : div_quo;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_quo <= {sum_mag, {FRAC_BITS{1'b0}}};
      div_rem <= '0;
      div_neg <= running_sum[SUM_W-1];
    end else if (cmd.div_step) begin
      div_quo <= {div_quo[DIV_W-2:0], trial_ge};
      div_rem <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_data.sample_count   <= COUNT_W'(samples_seen);
      result_data.average_q8     <= (samples_seen == '0) ? '0 : AVG_W'(quo_signed);
      result_data.largest_drop   <= drop_maximum;
      result_data.spike_count    <= SPIKE_W'(spikes_found);
      result_data.in_range_count <= COUNT_W'(in_range_found);
      result_data.overflow       <= overflowed;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    samples_seen <= MAX_COUNT)
    else $error("sample count beyond limit");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (samples_seen == '0 && !overflowed && running_sum == '0))
    else $error("statistics not cleared after result");

  a_overflow_only_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> samples_seen == MAX_COUNT)
    else $error("overflow flagged below the limit");

endmodule

`default_nettype wire

>>> hdl/sensor_sample_statistics_core.sv
// top level of the streaming sample statistics block
// after the last sample beat the controller steps through load, divide and hold, where it waits
// for a free result slot; throughput: one sample beat per cycle inside a set, none in between
// DIV_STEPS = 16 + clog2(MAX_SAMPLES+1) + 8 steps of the one-bit-per-cycle divider
// the next set streams in while a finished result waits in the output register
// reset: statistics cleared, threshold 100, range 90..110, no result held
`default_nettype none

module sensor_sample_statistics_core #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire                                clk,
  input  wire                                rst,
  // sample channel
  input  wire                                sample_valid,
  output logic                               sample_stall,
  input  ssstat_pkg::sample_item_t           sample_data,
  // result channel
  output logic                               result_valid,
  input  wire                                result_stall,
  output ssstat_pkg::result_item_t           result_data,
  // configuration write port
  input  wire                                cfg_write,
  input  wire [ssstat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [ssstat_pkg::CFG_W-1:0]        cfg_data
);
  import ssstat_pkg::*;

  // divider length follows the sum width: sample bits, count bits, fraction bits
  localparam int unsigned CNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DIV_STEPS = SAMPLE_BITS + CNT_W + FRAC_BITS;

  ssstat_cmd_t cmd;

  // controller: takes sample beats in the run state, sequences the divide after
  // the closing beat, then moves the result into the output register once free
  ssstat_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .last_sample  (sample_data.last_sample),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  // datapath: per-beat sum, count, drop, spike and range updates, an overflow flag
  // once the set is full, the serial divider for the q8 mean, and the result
  // register; statistics clear as the result is captured
  ssstat_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sample_data (sample_data),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result_data (result_data)
  );

endmodule

`default_nettype wire
